[rtl/lc3v_pkg.sv]
// lc3v_pkg: opcodes, trap functions, status codes and condition codes for the execute unit
// no dependencies
`default_nettype none
package lc3v_pkg;
    localparam logic [3:0] OP_BR   = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_LD   = 4'd2;
    localparam logic [3:0] OP_ST   = 4'd3;
    localparam logic [3:0] OP_JSR  = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_LDR  = 4'd6;
    localparam logic [3:0] OP_STR  = 4'd7;
    localparam logic [3:0] OP_MUL  = 4'd8;
    localparam logic [3:0] OP_NOT  = 4'd9;
    localparam logic [3:0] OP_LDI  = 4'd10;
    localparam logic [3:0] OP_STI  = 4'd11;
    localparam logic [3:0] OP_JMP  = 4'd12;
    localparam logic [3:0] OP_NEG  = 4'd13;
    localparam logic [3:0] OP_LEA  = 4'd14;
    localparam logic [3:0] OP_TRAP = 4'd15;

    localparam logic [2:0] TF_DIV   = 3'd0;
    localparam logic [2:0] TF_SAVE  = 3'd1;
    localparam logic [2:0] TF_OUT   = 3'd2;
    localparam logic [2:0] TF_KEY   = 3'd3;
    localparam logic [2:0] TF_HALT  = 3'd4;
    localparam logic [2:0] TF_REST  = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_DIVZERO = 3'd2;
    localparam logic [2:0] ST_MODZERO = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    localparam logic [2:0] CC_NEG  = 3'd4;
    localparam logic [2:0] CC_ZERO = 3'd2;
    localparam logic [2:0] CC_POS  = 3'd1;

    localparam logic [7:0] ASCII_ZERO = 8'd48;
endpackage
`default_nettype wire

[rtl/lc3_variant_execute_unit.sv]
// lc3_variant_execute_unit: sequenced execute unit with one shared 16-bit alu
// and a word memory; depends on lc3v_pkg
//
// channel  dir  handshake           payload
// in       in   in_valid/in_stall   kind instruction load_address load_data key_char
// out      out  out_valid/out_stall status char_valid out_char next_pc cond_flags is_halted
//
// path from acceptance: memory load items go straight to done; register instructions, st and str
// go decode, done; ld and ldr go decode, writeback, done; sti goes decode, pointer read, done; ldi adds writeback
// multiply steps one bit a cycle through the shared alu; divide and modulo step through div, then divfin
// memory has one write port and one read port, and the read is registered
// reset clears registers, pc, condition code, trap register and halt; memory is not cleared
// the input is stalled from acceptance until the result is taken
`default_nettype none
module lc3_variant_execute_unit #(
    parameter int MEM_WORDS = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [15:0] instruction,
    input  wire logic [15:0] load_address,
    input  wire logic [15:0] load_data,
    input  wire logic [7:0]  key_char,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic             char_valid,
    output logic [7:0]       out_char,
    output logic [15:0]      next_pc,
    output logic [2:0]       cond_flags,
    output logic             is_halted
);
    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_MEMRD, S_WB, S_MUL, S_DIV, S_DIVFIN, S_DONE
    } state_t;

    typedef enum logic [1:0] { A_ADD, A_AND, A_SUB, A_NOT } aluop_t;

    state_t      state_reg;
    logic [15:0] rf_reg [8];
    logic [15:0] pc_reg, tr_reg, ir_reg;
    logic [2:0]  cc_reg, status_reg;
    logic        halt_reg, cvalid_reg;
    logic [7:0]  key_reg, ochar_reg;
    logic [15:0] acc_reg, opa_reg, opb_reg;
    logic [4:0]  cnt_reg;
    logic [2:0]  wdr_reg;
    logic        is_div_reg;

    logic [15:0] mem [MEM_WORDS];
    logic [15:0] mrd_reg;
    logic        mwe;
    logic [AW-1:0] maddr, mwaddr;
    logic [15:0] mwdata;

    // instruction fields
    logic [3:0]  op;
    logic [2:0]  dr, sr1, sr2;
    logic        immf;
    logic [15:0] off9, off6, off11, imm5, pc1;
    assign op    = ir_reg[15:12];
    assign dr    = ir_reg[11:9];
    assign sr1   = ir_reg[8:6];
    assign sr2   = ir_reg[2:0];
    assign immf  = ir_reg[5];
    assign off9  = {{7{ir_reg[8]}}, ir_reg[8:0]};
    assign off6  = {{10{ir_reg[5]}}, ir_reg[5:0]};
    assign off11 = {{5{ir_reg[10]}}, ir_reg[10:0]};
    assign imm5  = {{11{ir_reg[4]}}, ir_reg[4:0]};
    assign pc1   = pc_reg + 16'd1;

    // the one shared alu
    aluop_t      alu_op;
    logic [15:0] alu_a, alu_b, alu_y;
    logic [16:0] alu_sub;
    assign alu_sub = {1'b0, alu_a} - {1'b0, alu_b};
    always_comb
    begin
        case (alu_op)
            A_ADD:   alu_y = alu_a + alu_b;
            A_AND:   alu_y = alu_a & alu_b;
            A_SUB:   alu_y = alu_sub[15:0];
            A_NOT:   alu_y = ~alu_a;
            default: alu_y = alu_a;
        endcase
    end

    function automatic logic [2:0] cc_of(input logic [15:0] v);
        logic [2:0] c;
        begin
            if (v == 16'd0) c = lc3v_pkg::CC_ZERO;
            else if (v[15]) c = lc3v_pkg::CC_NEG;
            else c = lc3v_pkg::CC_POS;
            return c;
        end
    endfunction

    // divider shift step: remainder in acc, quotient bits shift into opa
    logic [15:0] rem_sh;
    logic        rem_top;
    assign rem_top = acc_reg[15];
    assign rem_sh  = {acc_reg[14:0], opa_reg[15]};

    // alu operand select per state
    always_comb
    begin
        alu_op = A_ADD;
        alu_a  = pc1;
        alu_b  = off9;
        case (state_reg)
            S_DEC:
            begin
                case (op)
                    lc3v_pkg::OP_ADD:
                    begin
                        alu_a = rf_reg[sr1];
                        alu_b = immf ? imm5 : rf_reg[sr2];
                    end
                    lc3v_pkg::OP_AND:
                    begin
                        alu_op = A_AND;
                        alu_a  = rf_reg[sr1];
                        alu_b  = immf ? imm5 : rf_reg[sr2];
                    end
                    lc3v_pkg::OP_NOT:
                    begin
                        alu_op = A_NOT;
                        alu_a  = rf_reg[sr1];
                    end
                    lc3v_pkg::OP_NEG:
                    begin
                        alu_op = A_SUB;
                        alu_a  = 16'd0;
                        alu_b  = rf_reg[dr];
                    end
                    lc3v_pkg::OP_LDR, lc3v_pkg::OP_STR:
                    begin
                        alu_a = rf_reg[sr1];
                        alu_b = off6;
                    end
                    lc3v_pkg::OP_JSR:
                    begin
                        alu_b = off11;
                    end
                    default:
                    begin
                        alu_a = pc1;
                        alu_b = off9;
                    end
                endcase
            end
            S_MUL:
            begin
                alu_a = acc_reg;
                alu_b = opa_reg[cnt_reg[3:0]] ? (opb_reg << cnt_reg[3:0]) : 16'd0;
            end
            S_DIV:
            begin
                alu_op = A_SUB;
                alu_a  = rem_sh;
                alu_b  = opb_reg;
            end
            default:
            begin
                alu_a = pc1;
                alu_b = off9;
            end
        endcase
    end

    // pc and follow-up state leaving decode
    logic [15:0] pc_next;
    state_t      dec_state_next;
    always_comb
    begin
        pc_next        = pc1;
        dec_state_next = S_DONE;
        case (op)
            lc3v_pkg::OP_BR:
                if ((cc_reg & dr) != 3'd0) pc_next = alu_y;
            lc3v_pkg::OP_JSR:
                pc_next = ir_reg[11] ? alu_y : rf_reg[sr1];
            lc3v_pkg::OP_JMP:
                pc_next = rf_reg[sr1];
            lc3v_pkg::OP_LD, lc3v_pkg::OP_LDR:
                dec_state_next = S_WB;
            lc3v_pkg::OP_LDI, lc3v_pkg::OP_STI:
                dec_state_next = S_MEMRD;
            lc3v_pkg::OP_MUL:
            begin
                if (!immf)
                    dec_state_next = S_MUL;
                else if (rf_reg[sr2] != 16'd0)
                    dec_state_next = S_DIV;
            end
            lc3v_pkg::OP_TRAP:
            begin
                if ((ir_reg[2:0] == lc3v_pkg::TF_DIV) && (tr_reg != 16'd0))
                    dec_state_next = S_DIV;
            end
            default: ;
        endcase
    end

    // memory port
    always_comb
    begin
        mwe    = 1'b0;
        maddr  = alu_y[AW-1:0];
        mwaddr = alu_y[AW-1:0];
        mwdata = rf_reg[dr];
        if (state_reg == S_IDLE)
        begin
            mwe    = in_valid && kind;
            mwaddr = load_address[AW-1:0];
            mwdata = load_data;
        end
        else if (state_reg == S_DEC)
        begin
            mwe = (op == lc3v_pkg::OP_ST) || (op == lc3v_pkg::OP_STR);
        end
        else if (state_reg == S_MEMRD)
        begin
            maddr  = mrd_reg[AW-1:0];
            mwaddr = mrd_reg[AW-1:0];
            mwe    = (op == lc3v_pkg::OP_STI);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mwe)
            mem[mwaddr] <= mwdata;
        mrd_reg <= mem[maddr];
    end

    logic take_out;
    assign take_out = (state_reg == S_DONE) && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            for (int i = 0; i < 8; i++)
                rf_reg[i] <= 16'd0;
            pc_reg     <= 16'd0;
            tr_reg     <= 16'd0;
            cc_reg     <= 3'd0;
            halt_reg   <= 1'b0;
            status_reg <= lc3v_pkg::ST_OK;
            cvalid_reg <= 1'b0;
            ochar_reg  <= 8'd0;
            ir_reg     <= 16'd0;
            key_reg    <= 8'd0;
            acc_reg    <= 16'd0;
            opa_reg    <= 16'd0;
            opb_reg    <= 16'd0;
            cnt_reg    <= 5'd0;
            wdr_reg    <= 3'd0;
            is_div_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ir_reg     <= instruction;
                        key_reg    <= key_char;
                        cvalid_reg <= 1'b0;
                        ochar_reg  <= 8'd0;
                        if (kind)
                        begin
                            status_reg <= lc3v_pkg::ST_OK;
                            state_reg  <= S_DONE;
                        end
                        else if (halt_reg)
                        begin
                            status_reg <= lc3v_pkg::ST_IGNORED;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            status_reg <= lc3v_pkg::ST_OK;
                            state_reg  <= S_DEC;
                        end
                    end
                end
                S_DEC:
                begin
                    pc_reg    <= pc_next;
                    state_reg <= dec_state_next;
                    case (op)
                        lc3v_pkg::OP_ADD, lc3v_pkg::OP_AND, lc3v_pkg::OP_NOT,
                        lc3v_pkg::OP_NEG, lc3v_pkg::OP_LEA:
                        begin
                            rf_reg[dr] <= alu_y;
                            cc_reg     <= cc_of(alu_y);
                        end
                        lc3v_pkg::OP_MUL:
                        begin
                            opa_reg    <= rf_reg[sr1];
                            opb_reg    <= rf_reg[sr2];
                            acc_reg    <= 16'd0;
                            cnt_reg    <= 5'd0;
                            wdr_reg    <= dr;
                            is_div_reg <= 1'b0;
                            if (immf && (rf_reg[sr2] == 16'd0))
                            begin
                                halt_reg   <= 1'b1;
                                status_reg <= lc3v_pkg::ST_MODZERO;
                                cc_reg     <= cc_of(rf_reg[dr]);
                            end
                        end
                        lc3v_pkg::OP_TRAP:
                        begin
                            case (ir_reg[2:0])
                                lc3v_pkg::TF_DIV:
                                begin
                                    if (tr_reg == 16'd0)
                                    begin
                                        halt_reg   <= 1'b1;
                                        status_reg <= lc3v_pkg::ST_DIVZERO;
                                    end
                                    else
                                    begin
                                        opa_reg    <= rf_reg[ir_reg[7:5]];
                                        opb_reg    <= tr_reg;
                                        acc_reg    <= 16'd0;
                                        cnt_reg    <= 5'd0;
                                        wdr_reg    <= ir_reg[7:5];
                                        is_div_reg <= 1'b1;
                                    end
                                end
                                lc3v_pkg::TF_SAVE: tr_reg <= rf_reg[ir_reg[7:5]];
                                lc3v_pkg::TF_OUT:
                                begin
                                    cvalid_reg <= 1'b1;
                                    ochar_reg  <= tr_reg[7:0] + lc3v_pkg::ASCII_ZERO;
                                end
                                lc3v_pkg::TF_KEY:
                                    tr_reg <= {8'd0, key_reg} - {8'd0, lc3v_pkg::ASCII_ZERO};
                                lc3v_pkg::TF_HALT:
                                begin
                                    halt_reg   <= 1'b1;
                                    status_reg <= lc3v_pkg::ST_HALT;
                                end
                                lc3v_pkg::TF_REST: rf_reg[ir_reg[7:5]] <= tr_reg;
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
                S_MEMRD:
                    // pointer fetched; sti writes here, ldi reads the pointee
                    state_reg <= (op == lc3v_pkg::OP_LDI) ? S_WB : S_DONE;
                S_WB:
                begin
                    rf_reg[dr] <= mrd_reg;
                    cc_reg     <= cc_of(mrd_reg);
                    state_reg  <= S_DONE;
                end
                S_MUL:
                begin
                    acc_reg <= alu_y;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15)
                    begin
                        rf_reg[wdr_reg] <= alu_y;
                        cc_reg          <= cc_of(alu_y);
                        state_reg       <= S_DONE;
                    end
                end
                S_DIV:
                begin
                    // restoring division, one quotient bit a cycle
                    if (!rem_top && alu_sub[16])
                        acc_reg <= rem_sh;
                    else
                        acc_reg <= alu_y;
                    opa_reg <= {opa_reg[14:0], rem_top || !alu_sub[16]};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15)
                        state_reg <= S_DIVFIN;
                end
                S_DIVFIN:
                begin
                    rf_reg[wdr_reg] <= is_div_reg ? opa_reg : acc_reg;
                    cc_reg          <= cc_of(is_div_reg ? opa_reg : acc_reg);
                    state_reg       <= S_DONE;
                end
                S_DONE:
                    if (!out_stall)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = (state_reg == S_DONE);
    assign status     = status_reg;
    assign char_valid = cvalid_reg;
    assign out_char   = ochar_reg;
    assign next_pc    = pc_reg;
    assign cond_flags = cc_reg;
    assign is_halted  = halt_reg;

`ifndef SYNTHESIS
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input not stalled while result pending");
    a_ignored_halted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == lc3v_pkg::ST_IGNORED) |-> is_halted)
        else $error("ignored item while running");
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(halt_reg) |-> halt_reg) else $error("halt flag cleared");
    a_done_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        take_out |=> (state_reg == S_IDLE)) else $error("result taken but not idle");
`endif
endmodule
`default_nettype wire
